// ----- design/stable_priority_queue_top_macros.svh -----
// Assertion helpers used by the queue top module.
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
package spq_pkg;

   localparam int CAPACITY  = 16;
   localparam int TAG_BITS  = 16;

   // Width of the tag field on the ports.
   localparam int PORT_TAG_BITS = 16;
   // A stored tag keeps the low TAG_BITS bits of a port tag that is at most 16 wide.
   localparam int SLOT_TAG_BITS = (TAG_BITS < PORT_TAG_BITS) ? TAG_BITS : PORT_TAG_BITS;

   localparam int PRIO_BITS = 3;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);

   localparam logic [PRIO_BITS-1:0] MAX_PRIORITY = 3'd5;

   typedef enum logic [2:0] {
      ST_INSERTED     = 3'd0,
      ST_SERVED       = 3'd1,
      ST_EMPTY        = 3'd2,
      ST_FULL         = 3'd3,
      ST_BAD_PRIORITY = 3'd4
   } status_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef struct packed {
      logic [SLOT_TAG_BITS-1:0] tag;
      logic [PRIO_BITS-1:0]     prio;
   } slot_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic     insert;
      logic     remove;
      slot_type entry;
   } cmd_type;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell
   import spq_pkg::*;
(
   input  logic     clock,
   input  cmd_type  cmd,
   input  logic     occupied,
   input  logic     left_stays,
   input  slot_type left_slot,
   input  slot_type right_slot,
   output slot_type slot,
   output logic     stays
);

   slot_type slot_ff;
   slot_type slot_in;

   // A stored entry stays put when it is served no later than the new one.
   assign stays = occupied && (slot_ff.prio <= cmd.entry.prio);

   always_comb begin
      slot_in = slot_ff;
      if (cmd.insert) begin
         priority if (stays) begin
            slot_in = slot_ff;
         end else if (left_stays) begin
            slot_in = cmd.entry;
         end else begin
            slot_in = left_slot;
         end
      end else if (cmd.remove) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

// ----- design/stable_priority_queue_top.sv -----
// Stable priority queue. Each request word either inserts a tagged entry with a
// priority from 0 to 5 or removes the head entry, and each produces exactly one
// response word carrying a status, plus the tag and priority of a served entry.
// Lower priority numbers leave first, and entries of equal priority leave in the
// order they arrived. The entries live in a row of CAPACITY cells ordered from the
// head; every cell compares its own priority with the incoming one, and the row
// either opens a gap at the right place and drops the new entry in, or shifts
// every entry one cell toward the head, in one compare-and-shift step. The
// response is registered and appears in the cycle after acceptance, and a new
// request is accepted in every cycle as long as the response register can
// drain. The response register decouples the two sides, so a request is taken
// while the previous response is still waiting, unless that response is
// stalled.
module stable_priority_queue_top
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_entry_tag,
   input  logic [2:0]  req_entry_priority,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_served_tag,
   output logic [2:0]  rsp_served_priority
);

`include "stable_priority_queue_top_macros.svh"

   // Occupancy count: cells below it hold entries, in service order.
   logic [CNT_BITS-1:0] occupancy_ff;
   logic [CNT_BITS-1:0] occupancy_in;

   // Response register.
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               rsp_status_ff;
   status_type               rsp_status_in;
   logic [PORT_TAG_BITS-1:0] rsp_tag_ff;
   logic [PORT_TAG_BITS-1:0] rsp_tag_in;
   logic [PRIO_BITS-1:0]     rsp_prio_ff;
   logic [PRIO_BITS-1:0]     rsp_prio_in;

   logic     req_take;
   cmd_type  cmd;
   slot_type cell_slot [CAPACITY];
   logic     cell_stays [CAPACITY];
   logic     queue_empty;
   logic     queue_full;
   logic     prio_bad;

   // The response register frees up when it is empty or being drained.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign queue_empty = (occupancy_ff == '0);
   assign queue_full  = (occupancy_ff == CNT_BITS'(CAPACITY));
   assign prio_bad    = (req_entry_priority > MAX_PRIORITY);

   always_comb begin
      cmd.entry.tag  = req_entry_tag[SLOT_TAG_BITS-1:0];
      cmd.entry.prio = req_entry_priority;
      cmd.insert     = req_take && (req_action == ACT_INSERT) && !prio_bad && !queue_full;
      cmd.remove     = req_take && (req_action == ACT_REMOVE) && !queue_empty;
   end

   // The row of cells. The head cell has nothing to its left, so a new entry
   // lands there when it does not stay; the tail cell refills from itself.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (CNT_BITS'(i) < occupancy_ff),
         .left_stays ((i == 0) ? 1'b1 : cell_stays[(i == 0) ? 0 : i - 1]),
         .left_slot  (cell_slot[(i == 0) ? 0 : i - 1]),
         .right_slot (cell_slot[(i == CAPACITY - 1) ? i : i + 1]),
         .slot       (cell_slot[i]),
         .stays      (cell_stays[i])
      );
   end

   always_comb begin
      occupancy_in = occupancy_ff;
      if (cmd.insert) begin
         occupancy_in = occupancy_ff + CNT_BITS'(1);
      end else if (cmd.remove) begin
         occupancy_in = occupancy_ff - CNT_BITS'(1);
      end
   end

   // Status and served fields for the accepted word. Fields other than the
   // status are zero unless an entry was actually served.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = '0;
         rsp_prio_in  = '0;
         unique case (req_action)
            ACT_INSERT: begin
               priority if (prio_bad) begin
                  rsp_status_in = ST_BAD_PRIORITY;
               end else if (queue_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_INSERTED;
               end
            end
            ACT_REMOVE: begin
               if (queue_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_status_in = ST_SERVED;
                  rsp_tag_in    = PORT_TAG_BITS'(cell_slot[0].tag);
                  rsp_prio_in   = cell_slot[0].prio;
               end
            end
            default: begin
               rsp_status_in = ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occupancy_ff <= occupancy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_served_tag      = rsp_tag_ff;
   assign rsp_served_priority = rsp_prio_ff;

   // The count never runs past the number of cells.
   `SPQ_ASSERT_IMPLY(a_occ_bound, 1'b1, occupancy_ff <= CNT_BITS'(CAPACITY),
      "occupancy above capacity")
   // A completed insert grows the queue by exactly one entry.
   `SPQ_ASSERT_NEXT(a_insert_count, cmd.insert,
      occupancy_ff == $past(occupancy_ff) + CNT_BITS'(1), "insert did not count")
   // The two head cells stay in service order.
   `SPQ_ASSERT_IMPLY(a_head_order, occupancy_ff >= CNT_BITS'(2),
      cell_slot[0].prio <= cell_slot[1].prio, "head cells out of order")
   // Only a served word carries entry data, and never an illegal priority.
   `SPQ_ASSERT_IMPLY(a_served_fields, rsp_valid_ff && (rsp_status_ff != ST_SERVED),
      (rsp_tag_ff == '0) && (rsp_prio_ff == '0), "data on a word that served nothing")
   `SPQ_ASSERT_IMPLY(a_served_prio, rsp_valid_ff && (rsp_status_ff == ST_SERVED),
      rsp_prio_ff <= MAX_PRIORITY, "served entry has an illegal priority")

endmodule
